[src/mesh_vertex_area_accumulate_core_defines.svh]
// Assertion macros for the vertex area core.
`ifndef MESH_VERTEX_AREA_ACCUMULATE_CORE_DEFINES_SVH
`define MESH_VERTEX_AREA_ACCUMULATE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MVAA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mvaa assertion failed");

// Next-cycle implication, disabled during reset.
`define MVAA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mvaa assertion failed");

// Next-cycle implication, always checked.
`define MVAA_ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mvaa assertion failed");

`endif

[src/mvaa_pkg.sv]
package mvaa_pkg;

    localparam int VERTEX_COUNT = 1024;
    localparam int IDX_W        = $clog2(VERTEX_COUNT);
    localparam int COORD_W      = 24;
    localparam int POS_W        = 3 * COORD_W;
    localparam int AREA_W       = 56;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int W_W          = 2 * DIFF_W + 1;
    localparam int ACC_W        = 2 * W_W + 2;
    localparam int ROOT_W       = ACC_W / 2;
    localparam int REM_W        = ROOT_W + 4;
    localparam int MUL_STEPS    = W_W;
    localparam int SQ_STEPS     = ROOT_W;
    localparam int CNT_W        = $clog2(ROOT_W + 1);
    localparam int RCP_SHIFT    = 51;
    localparam logic [W_W-1:0] RCP_MUL = W_W'(((64'd1 << RCP_SHIFT) + 64'd1) / 64'd3);

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_FACE = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        VS_A   = 2'd0,
        VS_B   = 2'd1,
        VS_C   = 2'd2,
        VS_IDX = 2'd3
    } t_vsel;

    typedef enum logic [3:0] {
        MOP_UYVZ, MOP_UZVY, MOP_UZVX, MOP_UXVZ, MOP_UXVY, MOP_UYVX,
        MOP_SQX, MOP_SQY, MOP_SQZ, MOP_RCP
    } t_mop;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FETCH_A, ST_FETCH_B, ST_FETCH_C, ST_FETCH_END,
        ST_MUL_LD, ST_MUL_RUN, ST_MUL_END, ST_SQ_LD, ST_SQ_RUN,
        ST_AREA_RD, ST_AREA_WR, ST_READ_ADDR, ST_READ_WAIT
    } t_state;

    typedef struct packed {
        logic  capture;
        logic  load;
        t_vsel vsel;
        logic  pos_latch_en;
        t_vsel pos_latch_sel;
        logic  mul_ld;
        logic  mul_clr;
        logic  mul_run;
        t_mop  mul_op;
        logic  w_store;
        logic  sq_ld;
        logic  sq_run;
        logic  quo_store;
        logic  area_wr;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic cnt_last;
        logic out_free;
    } t_sts;

endpackage

[src/mvaa_if.sv]
interface mvaa_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [9:0]          vertex_index;
    logic signed [23:0]  pos_x;
    logic signed [23:0]  pos_y;
    logic signed [23:0]  pos_z;
    logic [9:0]          corner_a;
    logic [9:0]          corner_b;
    logic [9:0]          corner_c;

    modport source (output valid, kind, vertex_index, pos_x, pos_y, pos_z,
                    corner_a, corner_b, corner_c, input ready);
    modport sink (input valid, kind, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, output ready);
endinterface

interface mvaa_out_if;
    logic        valid;
    logic        ready;
    logic [55:0] vertex_area;
    logic        area_saturated;

    modport source (output valid, vertex_area, area_saturated, input ready);
    modport sink (input valid, vertex_area, area_saturated, output ready);
endinterface

[src/mvaa_ram.sv]
module mvaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/mvaa_datapath.sv]
module mvaa_datapath import mvaa_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic [IDX_W-1:0]          i_vertex_index,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    input  logic [IDX_W-1:0]          i_corner_a,
    input  logic [IDX_W-1:0]          i_corner_b,
    input  logic [IDX_W-1:0]          i_corner_c,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [AREA_W-1:0]         o_vertex_area,
    output logic                      o_area_saturated
);
    function automatic logic signed [DIFF_W-1:0] sx(input logic [COORD_W-1:0] c);
        return signed'({c[COORD_W-1], c});
    endfunction

    function automatic logic [DIFF_W-1:0] abs_d(input logic signed [DIFF_W-1:0] d);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    function automatic logic [W_W-1:0] abs_w(input logic signed [W_W-1:0] w);
        return w[W_W-1] ? W_W'(-w) : W_W'(w);
    endfunction

    logic [IDX_W-1:0]         r_ca, r_cb, r_cc, r_vi;
    logic [POS_W-1:0]         r_pa, r_pb, r_pc;
    logic signed [W_W-1:0]    r_wx, r_wy, r_wz;
    logic [ACC_W-1:0]         r_mc;
    logic [W_W-1:0]           r_mp;
    logic                     r_neg;
    logic [ACC_W-1:0]         r_acc;
    logic [CNT_W-1:0]         r_cnt;
    logic [REM_W-1:0]         r_rem;
    logic [ROOT_W-1:0]        r_root;
    logic                     r_out_valid;
    logic [AREA_W-1:0]        r_out_area;

    logic [IDX_W-1:0]         sel_addr;
    logic [POS_W-1:0]         pos_rdata;
    logic [AREA_W-1:0]        area_rdata;
    logic                     area_we;
    logic [IDX_W-1:0]         area_waddr;
    logic [AREA_W-1:0]        area_wdata;
    logic [AREA_W:0]          area_sum;
    logic signed [DIFF_W-1:0] ux, uy, uz, vx, vy, vz, op_a, op_b;
    logic                     op_sub, op_sq, op_rcp;
    logic signed [W_W-1:0]    op_w;
    logic [W_W-1:0]           m1, m2;
    logic                     m_neg;
    logic [REM_W-1:0]         rem_sh, trial;
    logic                     sq_ge;

    always_comb begin
        unique case (i_cmd.vsel)
            VS_A:    sel_addr = r_ca;
            VS_B:    sel_addr = r_cb;
            VS_C:    sel_addr = r_cc;
            default: sel_addr = r_vi;
        endcase
    end

    mvaa_ram #(.WIDTH(POS_W), .DEPTH(VERTEX_COUNT)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (i_vertex_index),
        .i_wdata ({i_pos_x, i_pos_y, i_pos_z}),
        .i_raddr (sel_addr),
        .o_rdata (pos_rdata)
    );

    assign area_sum   = {1'b0, area_rdata} + (AREA_W + 1)'(r_root);
    assign area_we    = i_cmd.load | i_cmd.area_wr;
    assign area_waddr = i_cmd.load ? i_vertex_index : sel_addr;
    assign area_wdata = i_cmd.load ? '0 : (area_sum[AREA_W] ? '1 : area_sum[AREA_W-1:0]);

    mvaa_ram #(.WIDTH(AREA_W), .DEPTH(VERTEX_COUNT)) u_area_ram (
        .i_clk   (i_clk),
        .i_we    (area_we),
        .i_waddr (area_waddr),
        .i_wdata (area_wdata),
        .i_raddr (sel_addr),
        .o_rdata (area_rdata)
    );

    assign ux = sx(r_pb[POS_W-1 -: COORD_W]) - sx(r_pa[POS_W-1 -: COORD_W]);
    assign uy = sx(r_pb[2*COORD_W-1 -: COORD_W]) - sx(r_pa[2*COORD_W-1 -: COORD_W]);
    assign uz = sx(r_pb[COORD_W-1:0]) - sx(r_pa[COORD_W-1:0]);
    assign vx = sx(r_pc[POS_W-1 -: COORD_W]) - sx(r_pa[POS_W-1 -: COORD_W]);
    assign vy = sx(r_pc[2*COORD_W-1 -: COORD_W]) - sx(r_pa[2*COORD_W-1 -: COORD_W]);
    assign vz = sx(r_pc[COORD_W-1:0]) - sx(r_pa[COORD_W-1:0]);

    always_comb begin
        op_a   = uy;
        op_b   = vz;
        op_sub = 1'b0;
        op_sq  = 1'b0;
        op_rcp = 1'b0;
        op_w   = r_wx;
        case (i_cmd.mul_op)
            MOP_UYVZ: begin op_a = uy; op_b = vz; end
            MOP_UZVY: begin op_a = uz; op_b = vy; op_sub = 1'b1; end
            MOP_UZVX: begin op_a = uz; op_b = vx; end
            MOP_UXVZ: begin op_a = ux; op_b = vz; op_sub = 1'b1; end
            MOP_UXVY: begin op_a = ux; op_b = vy; end
            MOP_UYVX: begin op_a = uy; op_b = vx; op_sub = 1'b1; end
            MOP_SQX:  begin op_sq = 1'b1; op_w = r_wx; end
            MOP_SQY:  begin op_sq = 1'b1; op_w = r_wy; end
            MOP_SQZ:  begin op_sq = 1'b1; op_w = r_wz; end
            MOP_RCP:  op_rcp = 1'b1;
            default:  op_sq = 1'b0;
        endcase
        if (op_rcp) begin
            m1    = r_root[ROOT_W-1:1];
            m2    = RCP_MUL;
            m_neg = 1'b0;
        end else if (op_sq) begin
            m1    = abs_w(op_w);
            m2    = abs_w(op_w);
            m_neg = 1'b0;
        end else begin
            m1    = W_W'(abs_d(op_a));
            m2    = W_W'(abs_d(op_b));
            m_neg = op_a[DIFF_W-1] ^ op_b[DIFF_W-1] ^ op_sub;
        end
    end

    assign rem_sh = {r_rem[REM_W-3:0], r_acc[ACC_W-1 -: 2]};
    assign trial  = REM_W'({r_root, 2'b01});
    assign sq_ge  = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_vi <= i_vertex_index;
            r_ca <= i_corner_a;
            r_cb <= i_corner_b;
            r_cc <= i_corner_c;
        end
        if (i_cmd.pos_latch_en) begin
            case (i_cmd.pos_latch_sel)
                VS_A:    r_pa <= pos_rdata;
                VS_B:    r_pb <= pos_rdata;
                default: r_pc <= pos_rdata;
            endcase
        end
        if (i_cmd.w_store) begin
            case (i_cmd.mul_op)
                MOP_UZVY: r_wx <= signed'(r_acc[W_W-1:0]);
                MOP_UXVZ: r_wy <= signed'(r_acc[W_W-1:0]);
                MOP_UYVX: r_wz <= signed'(r_acc[W_W-1:0]);
                default:  ;
            endcase
        end
        if (i_cmd.mul_ld) begin
            r_mc  <= ACC_W'(m1);
            r_mp  <= m2;
            r_neg <= m_neg;
            r_cnt <= CNT_W'(MUL_STEPS - 1);
            if (i_cmd.mul_clr) begin
                r_acc <= '0;
            end
        end else if (i_cmd.mul_run) begin
            if (r_mp[0]) begin
                r_acc <= r_neg ? r_acc - r_mc : r_acc + r_mc;
            end
            r_mc  <= {r_mc[ACC_W-2:0], 1'b0};
            r_mp  <= {1'b0, r_mp[W_W-1:1]};
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.sq_ld) begin
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_W'(SQ_STEPS - 1);
        end else if (i_cmd.sq_run) begin
            r_acc  <= {r_acc[ACC_W-3:0], 2'b00};
            r_rem  <= sq_ge ? rem_sh - trial : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], sq_ge};
            r_cnt  <= r_cnt - 1'b1;
        end else if (i_cmd.quo_store) begin
            r_root <= r_acc[RCP_SHIFT +: ROOT_W];
        end
        if (i_cmd.out_load) begin
            r_out_area <= area_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.cnt_last  = (r_cnt == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_vertex_area   = r_out_area;
    assign o_area_saturated = &r_out_area;
endmodule

[src/mvaa_ctrl.sv]
module mvaa_ctrl import mvaa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_kind,
    input  t_sts       i_sts,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);
    t_state r_state, n_state;
    t_mop   r_op, n_op;
    t_vsel  r_corner, n_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= MOP_UYVZ;
            r_corner <= VS_A;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_corner <= n_corner;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_corner   = r_corner;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.vsel   = VS_IDX;
        o_cmd.mul_op = r_op;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (t_kind'(i_in_kind))
                        KIND_LOAD: o_cmd.load = 1'b1;
                        KIND_FACE: n_state = ST_FETCH_A;
                        KIND_READ: n_state = ST_READ_ADDR;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FETCH_A: begin
                o_cmd.vsel = VS_A;
                n_state    = ST_FETCH_B;
            end
            ST_FETCH_B: begin
                o_cmd.vsel          = VS_B;
                o_cmd.pos_latch_en  = 1'b1;
                o_cmd.pos_latch_sel = VS_A;
                n_state             = ST_FETCH_C;
            end
            ST_FETCH_C: begin
                o_cmd.vsel          = VS_C;
                o_cmd.pos_latch_en  = 1'b1;
                o_cmd.pos_latch_sel = VS_B;
                n_state             = ST_FETCH_END;
            end
            ST_FETCH_END: begin
                o_cmd.pos_latch_en  = 1'b1;
                o_cmd.pos_latch_sel = VS_C;
                n_op                = MOP_UYVZ;
                n_state             = ST_MUL_LD;
            end
            ST_MUL_LD: begin
                o_cmd.mul_ld  = 1'b1;
                o_cmd.mul_clr = (r_op == MOP_UYVZ) || (r_op == MOP_UZVX) ||
                                (r_op == MOP_UXVY) || (r_op == MOP_SQX) ||
                                (r_op == MOP_RCP);
                n_state       = ST_MUL_RUN;
            end
            ST_MUL_RUN: begin
                o_cmd.mul_run = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_MUL_END;
                end
            end
            ST_MUL_END: begin
                if (r_op == MOP_RCP) begin
                    o_cmd.quo_store = 1'b1;
                    n_corner        = VS_A;
                    n_state         = ST_AREA_RD;
                end else begin
                    o_cmd.w_store = 1'b1;
                    if (r_op == MOP_SQZ) begin
                        n_state = ST_SQ_LD;
                    end else begin
                        n_op    = t_mop'(r_op + 4'd1);
                        n_state = ST_MUL_LD;
                    end
                end
            end
            ST_SQ_LD: begin
                o_cmd.sq_ld = 1'b1;
                n_state     = ST_SQ_RUN;
            end
            ST_SQ_RUN: begin
                o_cmd.sq_run = 1'b1;
                if (i_sts.cnt_last) begin
                    n_op    = MOP_RCP;
                    n_state = ST_MUL_LD;
                end
            end
            ST_AREA_RD: begin
                o_cmd.vsel = r_corner;
                n_state    = ST_AREA_WR;
            end
            ST_AREA_WR: begin
                o_cmd.vsel    = r_corner;
                o_cmd.area_wr = 1'b1;
                if (r_corner == VS_C) begin
                    n_state = ST_IDLE;
                end else begin
                    n_corner = t_vsel'(r_corner + 2'd1);
                    n_state  = ST_AREA_RD;
                end
            end
            ST_READ_ADDR: begin
                n_state = ST_READ_WAIT;
            end
            ST_READ_WAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

[src/mesh_vertex_area_accumulate_core.sv]
// Vertex area accumulator for a triangle mesh.
// i_req carries requests: kind 0 loads a vertex position and clears its
// area, kind 1 adds one third of a face's area to each of its corners,
// kind 2 reads one vertex's area; kind 3 is dropped.
// o_rsp returns one response per read request.
// Load: position and cleared area are written on acceptance. Read: the
// area is fetched, then loaded into the output register once it is free.
// Face: a bit-serial shift-add multiplier forms 9 products of 51 steps,
// then a 52-step square root, a divide by six as a tenth 51-step product
// with a reciprocal, then three read-modify-write passes on area memory.
// One request is in work at a time; i_req.ready is high while idle.
// A read response sits in an output register; while o_rsp.ready is low it
// holds, and the block keeps taking load and face requests. A further read
// waits inside the block until the register frees.
// Reset clears control only. Position and area memories are not cleared:
// read only vertices that were loaded.
module mesh_vertex_area_accumulate_core import mvaa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mvaa_in_if.sink     i_req,
    mvaa_out_if.source  o_rsp
);
    t_cmd cmd;
    t_sts sts;
    logic ready;

    mvaa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_kind  (i_req.kind),
        .i_sts      (sts),
        .o_in_ready (ready),
        .o_cmd      (cmd)
    );

    mvaa_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_vertex_index   (i_req.vertex_index),
        .i_pos_x          (i_req.pos_x),
        .i_pos_y          (i_req.pos_y),
        .i_pos_z          (i_req.pos_z),
        .i_corner_a       (i_req.corner_a),
        .i_corner_b       (i_req.corner_b),
        .i_corner_c       (i_req.corner_c),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_vertex_area    (o_rsp.vertex_area),
        .o_area_saturated (o_rsp.area_saturated)
    );

    assign i_req.ready = ready;
endmodule

[src/mvaa_checker.sv]
`include "mesh_vertex_area_accumulate_core_defines.svh"

module mvaa_checker import mvaa_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_kind,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [55:0] i_out_area,
    input logic        i_out_sat
);
    `MVAA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `MVAA_ASSERT_NEXT_ANY(a_reset_quiet, i_clk, !i_rst_n, !i_out_valid)
    `MVAA_ASSERT_NEXT(a_busy_after_work, i_clk, i_rst_n,
        i_in_valid && i_in_ready && (i_in_kind == KIND_FACE || i_in_kind == KIND_READ),
        !i_in_ready)
    `MVAA_ASSERT_IMP(a_sat_flag, i_clk, i_rst_n, i_out_valid, i_out_sat == (&i_out_area))
endmodule

bind mesh_vertex_area_accumulate_core mvaa_checker u_mvaa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_kind   (i_req.kind),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_area  (o_rsp.vertex_area),
    .i_out_sat   (o_rsp.area_saturated)
);
